/* rtl/core/pcr_pkg.sv */
// Types and fixed widths for the polygon clipper.
package pcr_pkg;

   localparam int CoordBits  = 16;
   localparam int DiffBits   = CoordBits + 1;
   localparam int ProdBits   = 2 * DiffBits;
   localparam int ResBits    = ProdBits + 2;
   localparam int DivCntBits = $clog2(ProdBits + 1);
   localparam int CsrAddrBits = 8;

   // Configuration register indexes
   localparam logic [CsrAddrBits-1:0] CSR_XMIN = 8'd0;
   localparam logic [CsrAddrBits-1:0] CSR_YMIN = 8'd1;
   localparam logic [CsrAddrBits-1:0] CSR_XMAX = 8'd2;
   localparam logic [CsrAddrBits-1:0] CSR_YMAX = 8'd3;

   typedef struct packed {
      logic signed [CoordBits-1:0] vx;
      logic signed [CoordBits-1:0] vy;
      logic                        last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [CoordBits-1:0] out_x;
      logic signed [CoordBits-1:0] out_y;
      logic                        last_out;
      logic                        empty_res;
      logic                        overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [CoordBits-1:0] x;
      logic signed [CoordBits-1:0] y;
   } vertex_type;

endpackage

/* rtl/core/pcr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pcr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/polygon_rect_clipper.sv */
// Sutherland-Hodgman polygon clipper against a configured rectangle.
// Loading: one vertex beat per cycle while busy is low; the marked beat starts clipping.
// Clipping: each pass walks the edges; a crossing is found by a multiply and a restoring
// divide; busy stays high until the last result beat is out.
// Output: after a setup state, one result beat per cycle; results cannot be stalled.
// Reset (synchronous, active high) clears control, counts and restores the rectangle.
module polygon_rect_clipper
   import pcr_pkg::*;
#(
   parameter int MAX_VERTS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CsrAddrBits-1:0] csr_addr,
   input  logic [CoordBits-1:0]   csr_wdata
);

   localparam int IW   = $clog2(MAX_VERTS);
   localparam int CNTW = $clog2(MAX_VERTS + 1);
   localparam logic [CNTW-1:0] MaxCnt = CNTW'(MAX_VERTS);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PASS  = 4'd1;
   localparam logic [3:0] ST_FIRST = 4'd2;
   localparam logic [3:0] ST_NEXT  = 4'd3;
   localparam logic [3:0] ST_EVAL  = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_FIX   = 4'd7;
   localparam logic [3:0] ST_WNEXT = 4'd8;
   localparam logic [3:0] ST_ADV   = 4'd9;
   localparam logic [3:0] ST_EMIT0 = 4'd10;
   localparam logic [3:0] ST_EMIT  = 4'd11;

   logic [3:0]                  state_ff, state_in;
   logic [1:0]                  pass_ff, pass_in;
   logic [CNTW-1:0]             cnt_ff, cnt_in;
   logic [CNTW-1:0]             wcnt_ff, wcnt_in;
   logic [CNTW-1:0]             idx_ff, idx_in;
   logic                        ovf_ff, ovf_in;
   logic signed [CoordBits-1:0] xmin_ff, ymin_ff, xmax_ff, ymax_ff;
   vertex_type                  cur_ff, cur_in, nxt_ff, nxt_in;

   // crossing operands and divider
   logic [DiffBits-1:0]         span_ff, span_in, tmag_ff, tmag_in, dd_ff, dd_in;
   logic                        neg_ff, neg_in;
   logic signed [CoordBits-1:0] base_ff, base_in, bnd_ff, bnd_in;
   logic [ProdBits-1:0]         quo_ff, quo_in;
   logic [DiffBits-1:0]         rem_ff, rem_in;
   logic [DivCntBits-1:0]       dcnt_ff, dcnt_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_data_ff, rsp_data_in;

   // RAM ports
   logic [IW-1:0]                  raddr;
   logic [$bits(vertex_type)-1:0]  rdata0, rdata1;
   vertex_type      rvtx;
   logic            we0, we1;
   logic [IW-1:0]   waddr0, waddr1;
   vertex_type      wdata0, wdata1;

   logic            keep_req;
   vertex_type      keep_vtx;
   logic            accept;

   // pass geometry
   logic                        axis_y;
   logic signed [CoordBits-1:0] bnd, pa, qa, pb, qb;
   logic                        cur_in_side, nxt_in_side;
   logic signed [DiffBits-1:0]  t_s, d_s, span_s;

   // divider step
   logic [DiffBits:0]           trial;
   logic                        ge;

   // crossing result
   logic signed [ResBits-1:0]   res_raw, res_fix;
   vertex_type                  cross_vtx;

   logic [CNTW-1:0]             idx_p1, idx_p2;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // boundary selection and in/out tests for the current pass
   always_comb begin
      axis_y = !pass_ff[1];
      case (pass_ff)
         2'd0:    bnd = ymin_ff;
         2'd1:    bnd = ymax_ff;
         2'd2:    bnd = xmax_ff;
         default: bnd = xmin_ff;
      endcase
      pa = axis_y ? cur_ff.y : cur_ff.x;
      qa = axis_y ? nxt_ff.y : nxt_ff.x;
      pb = axis_y ? cur_ff.x : cur_ff.y;
      qb = axis_y ? nxt_ff.x : nxt_ff.y;
      case (pass_ff)
         2'd0: begin
            cur_in_side = pa >= bnd;
            nxt_in_side = qa >= bnd;
         end
         2'd1, 2'd2: begin
            cur_in_side = pa <= bnd;
            nxt_in_side = qa <= bnd;
         end
         default: begin
            cur_in_side = pa >= bnd;
            nxt_in_side = qa >= bnd;
         end
      endcase
      t_s    = DiffBits'(bnd) - DiffBits'(pa);
      d_s    = DiffBits'(qa) - DiffBits'(pa);
      span_s = DiffBits'(qb) - DiffBits'(pb);
   end

   // restoring divide step
   assign trial = {rem_ff, quo_ff[ProdBits-1]};
   assign ge    = trial >= {1'b0, dd_ff};

   // truncate toward zero after the floor of the magnitudes
   always_comb begin
      res_raw = neg_ff ? (ResBits'(base_ff) - $signed({2'b00, quo_ff}))
                       : (ResBits'(base_ff) + $signed({2'b00, quo_ff}));
      res_fix = res_raw;
      if (rem_ff != '0) begin
         if (!neg_ff && res_raw < 0) begin
            res_fix = res_raw + ResBits'(1);
         end else if (neg_ff && res_raw >= 1) begin
            res_fix = res_raw - ResBits'(1);
         end
      end
      if (axis_y) begin
         cross_vtx.x = res_fix[CoordBits-1:0];
         cross_vtx.y = bnd_ff;
      end else begin
         cross_vtx.x = bnd_ff;
         cross_vtx.y = res_fix[CoordBits-1:0];
      end
   end

   assign idx_p1 = idx_ff + CNTW'(1);
   assign idx_p2 = idx_ff + CNTW'(2);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      cnt_in       = cnt_ff;
      wcnt_in      = wcnt_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      span_in      = span_ff;
      tmag_in      = tmag_ff;
      dd_in        = dd_ff;
      neg_in       = neg_ff;
      base_in      = base_ff;
      bnd_in       = bnd_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      raddr        = '0;
      keep_req     = 1'b0;
      keep_vtx     = nxt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (cnt_ff < MaxCnt) begin
                  cnt_in = cnt_ff + CNTW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_vertex) begin
                  pass_in  = 2'd0;
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            wcnt_in = '0;
            idx_in  = '0;
            raddr   = '0;
            if (cnt_ff == '0) begin
               if (pass_ff == 2'd3) begin
                  state_in = ST_EMIT0;
               end else begin
                  pass_in = pass_ff + 2'd1;
               end
            end else begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            cur_in   = rvtx;
            raddr    = (idx_p1 == cnt_ff) ? '0 : idx_p1[IW-1:0];
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            nxt_in   = rvtx;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            span_in = span_s[DiffBits-1] ? DiffBits'(-span_s) : DiffBits'(span_s);
            tmag_in = t_s[DiffBits-1] ? DiffBits'(-t_s) : DiffBits'(t_s);
            dd_in   = d_s[DiffBits-1] ? DiffBits'(-d_s) : DiffBits'(d_s);
            neg_in  = span_s[DiffBits-1] ^ t_s[DiffBits-1] ^ d_s[DiffBits-1];
            base_in = pb;
            bnd_in  = bnd;
            if (cur_in_side && nxt_in_side) begin
               keep_req = 1'b1;
               keep_vtx = nxt_ff;
               state_in = ST_ADV;
            end else if (cur_in_side || nxt_in_side) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_MUL: begin
            quo_in   = ProdBits'(span_ff) * ProdBits'(tmag_ff);
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = ge ? DiffBits'(trial - {1'b0, dd_ff}) : trial[DiffBits-1:0];
            quo_in  = {quo_ff[ProdBits-2:0], ge};
            dcnt_in = dcnt_ff + DivCntBits'(1);
            if (dcnt_ff == DivCntBits'(ProdBits - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            keep_req = 1'b1;
            keep_vtx = cross_vtx;
            state_in = nxt_in_side ? ST_WNEXT : ST_ADV;
         end
         ST_WNEXT: begin
            keep_req = 1'b1;
            keep_vtx = nxt_ff;
            state_in = ST_ADV;
         end
         ST_ADV: begin
            cur_in = nxt_ff;
            idx_in = idx_p1;
            raddr  = (idx_p2 == cnt_ff) ? '0 : idx_p2[IW-1:0];
            if (idx_p1 == cnt_ff) begin
               cnt_in = wcnt_ff;
               if (pass_ff == 2'd3) begin
                  state_in = ST_EMIT0;
               end else begin
                  pass_in  = pass_ff + 2'd1;
                  state_in = ST_PASS;
               end
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_EMIT0: begin
            idx_in = '0;
            raddr  = '0;
            if (cnt_ff == '0) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_x     = '0;
               rsp_data_in.out_y     = '0;
               rsp_data_in.last_out  = 1'b1;
               rsp_data_in.empty_res = 1'b1;
               rsp_data_in.overflow  = ovf_ff;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.out_x     = rvtx.x;
            rsp_data_in.out_y     = rvtx.y;
            rsp_data_in.last_out  = (idx_p1 == cnt_ff);
            rsp_data_in.empty_res = 1'b0;
            rsp_data_in.overflow  = ovf_ff;
            raddr  = idx_p1[IW-1:0];
            idx_in = idx_p1;
            if (idx_p1 == cnt_ff) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // output capacity of a pass
      if (keep_req) begin
         if (wcnt_ff < MaxCnt) begin
            wcnt_in = wcnt_ff + CNTW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // bank 0 takes the load and the odd passes, bank 1 the even passes
   always_comb begin
      we0    = 1'b0;
      waddr0 = wcnt_ff[IW-1:0];
      wdata0 = keep_vtx;
      we1    = keep_req && (wcnt_ff < MaxCnt) && !pass_ff[0];
      waddr1 = wcnt_ff[IW-1:0];
      wdata1 = keep_vtx;
      if (accept) begin
         we0    = cnt_ff < MaxCnt;
         waddr0 = cnt_ff[IW-1:0];
         wdata0.x = req_data.vx;
         wdata0.y = req_data.vy;
      end else begin
         we0 = keep_req && (wcnt_ff < MaxCnt) && pass_ff[0];
      end
   end

   assign rvtx = (pass_ff[0] && state_ff != ST_EMIT) ? vertex_type'(rdata1)
                                                     : vertex_type'(rdata0);

   pcr_ram #(.WIDTH($bits(vertex_type)), .DEPTH(MAX_VERTS)) u_store_a (
      .clock (clock),
      .we    (we0),
      .waddr (waddr0),
      .wdata (wdata0),
      .raddr (raddr),
      .rdata (rdata0)
   );

   pcr_ram #(.WIDTH($bits(vertex_type)), .DEPTH(MAX_VERTS)) u_store_b (
      .clock (clock),
      .we    (we1),
      .waddr (waddr1),
      .wdata (wdata1),
      .raddr (raddr),
      .rdata (rdata1)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= 2'd0;
         cnt_ff       <= '0;
         wcnt_ff      <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         cnt_ff       <= cnt_in;
         wcnt_ff      <= wcnt_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // clip rectangle
   always_ff @(posedge clock) begin
      if (reset) begin
         xmin_ff <= 16'sd150;
         ymin_ff <= 16'sd150;
         xmax_ff <= 16'sd300;
         ymax_ff <= 16'sd300;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_XMIN: xmin_ff <= csr_wdata;
            CSR_YMIN: ymin_ff <= csr_wdata;
            CSR_XMAX: xmax_ff <= csr_wdata;
            CSR_YMAX: ymax_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      span_ff     <= span_in;
      tmag_ff     <= tmag_in;
      dd_ff       <= dd_in;
      neg_ff      <= neg_in;
      base_ff     <= base_in;
      bnd_ff      <= bnd_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
